@@ hdl/mau_pkg.sv @@
// Shared types and constants of the modular arithmetic unit.
// Used by mau_ctrl, mau_dp and modular_arithmetic_unit_top; depends on nothing.
package mau_pkg;

  localparam int unsigned ResW    = 31;
  localparam int unsigned RawW    = 64;
  localparam int unsigned ExpW    = 64;
  localparam int unsigned CntW    = 6;
  localparam logic [ResW-1:0] ModReset = 31'd1000000007;
  localparam logic [CntW-1:0] RedLast  = CntW'(RawW - 1);
  localparam logic [CntW-1:0] MulLast  = CntW'(ResW - 1);

  typedef enum logic [2:0] {
    OP_RED = 3'd0,
    OP_ADD = 3'd1,
    OP_SUB = 3'd2,
    OP_NEG = 3'd3,
    OP_MUL = 3'd4,
    OP_DIV = 3'd5,
    OP_POW = 3'd6,
    OP_INV = 3'd7
  } mau_op_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RED_STEP,
    CMD_WB_A,
    CMD_WB_B,
    CMD_FIN_ALU,
    CMD_INV_SETUP,
    CMD_POW_SETUP,
    CMD_MUL_AB,
    CMD_MUL_AX,
    CMD_MUL_XX,
    CMD_MUL_AACC,
    CMD_MUL_STEP,
    CMD_WB_ACC,
    CMD_WB_X,
    CMD_RES_P,
    CMD_RES_ACC,
    CMD_RES_ZERO
  } mau_cmd_e;

  typedef struct packed {
    mau_cmd_e cmd;
  } mau_ctl_t;

  typedef struct packed {
    logic red_last;
    logic mul_last;
    logic m_small;
    logic e_zero;
    logic e_lsb;
  } mau_sts_t;

endpackage

@@ hdl/mau_dp.sv @@
// Datapath: modulus register, bit-serial remainder and shift-add modular multiplier.
// Depends on mau_pkg; driven by mau_ctrl through mau_ctl_t.
module mau_dp import mau_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [ResW-1:0]        cfg_wdata_i,
  input  logic [2:0]             opcode_i,
  input  logic signed [RawW-1:0] raw_value_i,
  input  logic [ResW-1:0]        operand_a_i,
  input  logic [ResW-1:0]        operand_b_i,
  input  logic signed [ExpW-1:0] exponent_i,
  input  mau_ctl_t               ctl_i,
  output mau_sts_t               sts_o,
  output logic [ResW-1:0]        result_o,
  output logic                   is_zero_o
);

  logic [ResW-1:0] m_q;
  mau_op_e         op_q;
  logic            neg_q;
  logic [ResW-1:0] a_q, b_q, acc_q, x_q, p_q, mx_q, mb_q, r_q, res_q;
  logic [ExpW-1:0] e_q;
  logic [RawW-1:0] sh_q;
  logic [CntW-1:0] cnt_q;

  logic [ResW:0]   rsh, rnx, t0, t1, t2, t3, alu_s;
  logic [ResW-1:0] alu_res, inv_base;
  logic [RawW-1:0] raw_mag;

  always_comb begin
    rsh = {r_q, sh_q[RawW-1]};
    rnx = (rsh >= {1'b0, m_q}) ? rsh - {1'b0, m_q} : rsh;
    t0  = {p_q, 1'b0};
    t1  = (t0 >= {1'b0, m_q}) ? t0 - {1'b0, m_q} : t0;
    t2  = t1 + (mb_q[ResW-1] ? {1'b0, mx_q} : '0);
    t3  = (t2 >= {1'b0, m_q}) ? t2 - {1'b0, m_q} : t2;
    raw_mag = raw_value_i[RawW-1] ? (~raw_value_i + RawW'(1)) : raw_value_i;
    inv_base = (op_q == OP_INV) ? a_q : b_q;
    alu_s = '0;
    case (op_q)
      OP_RED: begin
        alu_res = (neg_q && r_q != '0) ? m_q - r_q : r_q;
      end
      OP_ADD: begin
        alu_s   = {1'b0, a_q} + {1'b0, b_q};
        alu_res = (alu_s >= {1'b0, m_q}) ? ResW'(alu_s - {1'b0, m_q}) : alu_s[ResW-1:0];
      end
      OP_SUB: begin
        alu_s   = {1'b0, a_q} + {1'b0, m_q} - {1'b0, b_q};
        alu_res = (a_q >= b_q) ? a_q - b_q : alu_s[ResW-1:0];
      end
      OP_NEG: begin
        alu_res = (a_q == '0) ? '0 : m_q - a_q;
      end
      default: begin
        alu_res = r_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q   <= ModReset;
      cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        m_q <= cfg_wdata_i;
      end
      case (ctl_i.cmd)
        CMD_LOAD: begin
          op_q  <= mau_op_e'(opcode_i);
          neg_q <= raw_value_i[RawW-1];
          e_q   <= exponent_i;
          a_q   <= operand_a_i;
          b_q   <= operand_b_i;
          sh_q  <= (mau_op_e'(opcode_i) == OP_RED) ? raw_mag
                                                    : {{(RawW-ResW){1'b0}}, operand_a_i};
          r_q   <= '0;
          cnt_q <= '0;
        end
        CMD_RED_STEP: begin
          r_q   <= rnx[ResW-1:0];
          sh_q  <= {sh_q[RawW-2:0], 1'b0};
          cnt_q <= cnt_q + CntW'(1);
        end
        CMD_WB_A: begin
          a_q   <= r_q;
          sh_q  <= {{(RawW-ResW){1'b0}}, b_q};
          r_q   <= '0;
          cnt_q <= '0;
        end
        CMD_WB_B: begin
          b_q <= r_q;
        end
        CMD_FIN_ALU: begin
          res_q <= alu_res;
        end
        CMD_INV_SETUP: begin
          x_q   <= inv_base;
          acc_q <= (inv_base == '0) ? '0 : ResW'(1);
          e_q   <= (inv_base == '0) ? '0 : {{(ExpW-ResW){1'b0}}, m_q - ResW'(2)};
        end
        CMD_POW_SETUP: begin
          x_q   <= a_q;
          acc_q <= ResW'(1);
          if (e_q[ExpW-1]) begin
            e_q <= '0;
          end
        end
        CMD_MUL_AB: begin
          p_q <= '0; mx_q <= a_q; mb_q <= b_q; cnt_q <= '0;
        end
        CMD_MUL_AX: begin
          p_q <= '0; mx_q <= acc_q; mb_q <= x_q; cnt_q <= '0;
        end
        CMD_MUL_XX: begin
          p_q <= '0; mx_q <= x_q; mb_q <= x_q; cnt_q <= '0;
        end
        CMD_MUL_AACC: begin
          p_q <= '0; mx_q <= a_q; mb_q <= acc_q; cnt_q <= '0;
        end
        CMD_MUL_STEP: begin
          p_q   <= t3[ResW-1:0];
          mb_q  <= {mb_q[ResW-2:0], 1'b0};
          cnt_q <= cnt_q + CntW'(1);
        end
        CMD_WB_ACC: begin
          acc_q <= p_q;
        end
        CMD_WB_X: begin
          x_q <= p_q;
          e_q <= {1'b0, e_q[ExpW-1:1]};
        end
        CMD_RES_P: begin
          res_q <= p_q;
        end
        CMD_RES_ACC: begin
          res_q <= acc_q;
        end
        CMD_RES_ZERO: begin
          res_q <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign sts_o.red_last = (cnt_q == RedLast);
  assign sts_o.mul_last = (cnt_q == MulLast);
  assign sts_o.m_small  = (m_q < ResW'(2));
  assign sts_o.e_zero   = (e_q == '0);
  assign sts_o.e_lsb    = e_q[0];
  assign result_o       = res_q;
  assign is_zero_o      = (res_q == '0);

endmodule

@@ hdl/mau_ctrl.sv @@
// Controller: sequences reduction, ALU, multiply and power rounds.
// Depends on mau_pkg; commands mau_dp through mau_ctl_t.
module mau_ctrl import mau_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [2:0] opcode_i,
  input  mau_sts_t   sts_i,
  output mau_ctl_t   ctl_o,
  output logic       busy,
  output logic       done_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_RED_A, S_WB_A, S_RED_B, S_WB_B, S_FIN, S_ZERO,
    S_MUL_AB, S_INV_SET, S_POW_SET, S_PCHK, S_MUL_AX, S_WB_ACC,
    S_MUL_XX, S_WB_X, S_MUL_AACC, S_MRUN, S_RES_P, S_RES_ACC
  } state_e;

  state_e  state_q, ret_q;
  mau_op_e op_q;
  logic    done_q;

  always_comb begin
    case (state_q)
      S_IDLE:     ctl_o.cmd = start ? CMD_LOAD : CMD_NONE;
      S_RED_A:    ctl_o.cmd = CMD_RED_STEP;
      S_RED_B:    ctl_o.cmd = CMD_RED_STEP;
      S_WB_A:     ctl_o.cmd = CMD_WB_A;
      S_WB_B:     ctl_o.cmd = CMD_WB_B;
      S_FIN:      ctl_o.cmd = CMD_FIN_ALU;
      S_ZERO:     ctl_o.cmd = CMD_RES_ZERO;
      S_MUL_AB:   ctl_o.cmd = CMD_MUL_AB;
      S_INV_SET:  ctl_o.cmd = CMD_INV_SETUP;
      S_POW_SET:  ctl_o.cmd = CMD_POW_SETUP;
      S_MUL_AX:   ctl_o.cmd = CMD_MUL_AX;
      S_WB_ACC:   ctl_o.cmd = CMD_WB_ACC;
      S_MUL_XX:   ctl_o.cmd = CMD_MUL_XX;
      S_WB_X:     ctl_o.cmd = CMD_WB_X;
      S_MUL_AACC: ctl_o.cmd = CMD_MUL_AACC;
      S_MRUN:     ctl_o.cmd = CMD_MUL_STEP;
      S_RES_P:    ctl_o.cmd = CMD_RES_P;
      S_RES_ACC:  ctl_o.cmd = CMD_RES_ACC;
      default:    ctl_o.cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      op_q    <= OP_RED;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            op_q    <= mau_op_e'(opcode_i);
            state_q <= sts_i.m_small ? S_ZERO : S_RED_A;
          end
        end
        S_RED_A: begin
          if (sts_i.red_last) begin
            state_q <= (op_q == OP_RED) ? S_FIN : S_WB_A;
          end
        end
        S_WB_A: state_q <= S_RED_B;
        S_RED_B: begin
          if (sts_i.red_last) begin
            state_q <= S_WB_B;
          end
        end
        S_WB_B: begin
          case (op_q)
            OP_MUL:  state_q <= S_MUL_AB;
            OP_DIV:  state_q <= S_INV_SET;
            OP_INV:  state_q <= S_INV_SET;
            OP_POW:  state_q <= S_POW_SET;
            default: state_q <= S_FIN;
          endcase
        end
        S_MUL_AB: begin
          state_q <= S_MRUN;
          ret_q   <= S_RES_P;
        end
        S_INV_SET: state_q <= S_PCHK;
        S_POW_SET: state_q <= S_PCHK;
        S_PCHK: begin
          if (sts_i.e_zero) begin
            state_q <= (op_q == OP_DIV) ? S_MUL_AACC : S_RES_ACC;
          end else begin
            state_q <= sts_i.e_lsb ? S_MUL_AX : S_MUL_XX;
          end
        end
        S_MUL_AX: begin
          state_q <= S_MRUN;
          ret_q   <= S_WB_ACC;
        end
        S_WB_ACC: state_q <= S_MUL_XX;
        S_MUL_XX: begin
          state_q <= S_MRUN;
          ret_q   <= S_WB_X;
        end
        S_WB_X: state_q <= S_PCHK;
        S_MUL_AACC: begin
          state_q <= S_MRUN;
          ret_q   <= S_RES_P;
        end
        S_MRUN: begin
          if (sts_i.mul_last) begin
            state_q <= ret_q;
          end
        end
        S_FIN, S_ZERO, S_RES_P, S_RES_ACC: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result beat while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) start && !busy |=> busy)
    else $error("accepted beat did not start work");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result beat repeated");

endmodule

@@ hdl/modular_arithmetic_unit_top.sv @@
// Prime-field arithmetic unit: one result beat, strobed by done_o, for each accepted
// command. The receiver cannot stall; result_o and is_zero_o stay until the next result.
// A 64-step bit-serial remainder runs per operand. A shift-add modular multiplier serves
// mul, pow, inv and div. Each exponent bit costs a squaring, plus a multiply into the
// accumulator when the bit is set.
// Depends on mau_pkg, mau_ctrl and mau_dp.
module modular_arithmetic_unit_top import mau_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   cfg_we_i,
  input  logic [ResW-1:0]        cfg_wdata_i,
  input  logic [2:0]             opcode_i,
  input  logic signed [RawW-1:0] raw_value_i,
  input  logic [ResW-1:0]        operand_a_i,
  input  logic [ResW-1:0]        operand_b_i,
  input  logic signed [ExpW-1:0] exponent_i,
  output logic                   done_o,
  output logic [ResW-1:0]        result_o,
  output logic                   is_zero_o
);

  mau_ctl_t ctl;
  mau_sts_t sts;

  mau_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .sts_i    (sts),
    .ctl_o    (ctl),
    .busy     (busy),
    .done_o   (done_o)
  );

  mau_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .opcode_i    (opcode_i),
    .raw_value_i (raw_value_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .exponent_i  (exponent_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .result_o    (result_o),
    .is_zero_o   (is_zero_o)
  );

endmodule
